// ===== hdl/motor_current_lut_interpolator_defines.svh =====
// assertion macros
`ifndef MOTOR_CURRENT_LUT_INTERPOLATOR_DEFINES_SVH
`define MOTOR_CURRENT_LUT_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define MCLUT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MCLUT_ASSERT_RST(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("reset check failed");
`else
`define MCLUT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCLUT_ASSERT_RST(label, clk, rst_n, cons)
`endif
`endif

// ===== hdl/mclut_pkg.sv =====
package mclut_pkg;

  localparam int SPEED_ROWS_DEF     = 128;
  localparam int TORQUE_COLS_DEF    = 32;
  localparam int VOLTAGE_LAYERS_DEF = 3;

  localparam int ROW_MAX_W   = 10;
  localparam int COL_MAX_W   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] TBL_TORQUE = 2'd0;
  localparam logic [1:0] TBL_D      = 2'd1;
  localparam logic [1:0] TBL_Q      = 2'd2;
  localparam logic [1:0] SEL_D      = 2'd0;
  localparam logic [1:0] SEL_Q      = 2'd1;

  localparam logic [1:0] LAYER_400 = 2'd0;
  localparam logic [1:0] LAYER_500 = 2'd1;
  localparam logic [1:0] LAYER_600 = 2'd2;

  localparam logic [13:0] BV_400 = 14'd4000;
  localparam logic [13:0] BV_500 = 14'd5000;
  localparam logic [13:0] BV_600 = 14'd6000;

  localparam logic [16:0] FRAC_ONE = 17'h10000;
  localparam logic [6:0]  RPM_STEP = 7'd100;

  // reciprocal multipliers for the constant divides
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_100_SH = 19;
  localparam logic [21:0] FS_RECIP     = 22'd2684355;
  localparam int          FS_SH        = 12;
  localparam logic [23:0] FV_RECIP     = 24'd8589935;
  localparam int          FV_SH        = 17;

  typedef struct packed {
    logic                  op;
    logic [1:0]            tbl;
    logic [1:0]            layer_lo;
    logic [1:0]            layer_hi;
    logic [ROW_MAX_W-1:0]  row;
    logic [COL_MAX_W-1:0]  col;
    logic signed [15:0]    value;
    logic [15:0]           trq;
    logic [15:0]           fs;
    logic [15:0]           fv;
  } item_t;

endpackage

// ===== hdl/mclut_front.sv =====
module mclut_front #(
  parameter int SPEED_ROWS     = mclut_pkg::SPEED_ROWS_DEF,
  parameter int TORQUE_COLS    = mclut_pkg::TORQUE_COLS_DEF,
  parameter int VOLTAGE_LAYERS = mclut_pkg::VOLTAGE_LAYERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [1:0]         in_load_table,
  input  logic [1:0]         in_load_layer,
  input  logic [6:0]         in_load_row,
  input  logic [4:0]         in_load_col,
  input  logic signed [15:0] in_load_value,
  input  logic signed [15:0] in_speed_rpm,
  input  logic signed [15:0] in_torque_request,
  input  logic [13:0]        in_bus_voltage,
  input  logic [1:0]         in_current_select,
  output mclut_pkg::item_t   push_item,
  output logic               push,
  input  logic               full
);

  localparam int RW = mclut_pkg::ROW_MAX_W;
  localparam int CW = mclut_pkg::COL_MAX_W;

  localparam logic [1:0] PH_REM  = 2'd0;
  localparam logic [1:0] PH_FS   = 2'd1;
  localparam logic [1:0] PH_PUSH = 2'd2;

  logic             busy_r;
  logic [1:0]       ph_r;
  mclut_pkg::item_t item_r;
  logic [15:0]      abs_r;
  logic [8:0]       row_r;
  logic [9:0]       dv_r;
  logic [6:0]       rem_r;

  logic             accept;
  logic             load_ok;
  logic [15:0]      abs_spd;
  logic [15:0]      abs_trq;
  logic [28:0]      row_prod;
  logic [1:0]       lay_lo;
  logic [1:0]       lay_hi;
  logic [9:0]       dv;
  logic [RW-1:0]    row_clamp;
  logic [33:0]      fv_prod;
  logic [28:0]      fs_prod;

  always_comb begin
    in_ready  = !busy_r;
    accept    = in_valid && in_ready;
    push      = busy_r && (ph_r == PH_PUSH) && !full;
    push_item = item_r;
    load_ok   = (in_load_table <= mclut_pkg::TBL_Q) &&
                (32'(in_load_layer) < VOLTAGE_LAYERS) &&
                (32'(in_load_row) < SPEED_ROWS) &&
                (32'(in_load_col) < TORQUE_COLS);
    abs_spd   = in_speed_rpm[15] ? 16'(-in_speed_rpm) : 16'(in_speed_rpm);
    abs_trq   = in_torque_request[15] ? 16'(-in_torque_request) : 16'(in_torque_request);
    row_prod  = 29'(abs_spd) * 29'(mclut_pkg::RECIP_100);
    if (in_bus_voltage < mclut_pkg::BV_400) begin
      lay_lo = mclut_pkg::LAYER_400;
      lay_hi = mclut_pkg::LAYER_400;
      dv     = '0;
    end else if (in_bus_voltage < mclut_pkg::BV_500) begin
      lay_lo = mclut_pkg::LAYER_400;
      lay_hi = mclut_pkg::LAYER_500;
      dv     = 10'(in_bus_voltage - mclut_pkg::BV_400);
    end else if (in_bus_voltage < mclut_pkg::BV_600) begin
      lay_lo = mclut_pkg::LAYER_500;
      lay_hi = mclut_pkg::LAYER_600;
      dv     = 10'(in_bus_voltage - mclut_pkg::BV_500);
    end else begin
      lay_lo = mclut_pkg::LAYER_600;
      lay_hi = mclut_pkg::LAYER_600;
      dv     = '0;
    end
    row_clamp = (32'(row_r) >= SPEED_ROWS - 1) ? RW'(SPEED_ROWS - 2) : RW'(row_r);
    fv_prod   = 34'(dv_r) * 34'(mclut_pkg::FV_RECIP);
    fs_prod   = 29'(rem_r) * 29'(mclut_pkg::FS_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= PH_REM;
    end else if (accept) begin
      if (in_operation == mclut_pkg::OP_LOAD) begin
        busy_r <= load_ok;
        ph_r   <= PH_PUSH;
      end else begin
        busy_r <= 1'b1;
        ph_r   <= PH_REM;
      end
    end else if (busy_r) begin
      unique case (ph_r)
        PH_REM:  ph_r <= PH_FS;
        PH_FS:   ph_r <= PH_PUSH;
        PH_PUSH: if (!full) busy_r <= 1'b0;
        default: ph_r <= PH_REM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op       <= in_operation;
      item_r.value    <= in_load_value;
      item_r.trq      <= abs_trq;
      item_r.fs       <= '0;
      item_r.fv       <= '0;
      abs_r           <= abs_spd;
      row_r           <= 9'(row_prod >> mclut_pkg::RECIP_100_SH);
      dv_r            <= dv;
      if (in_operation == mclut_pkg::OP_LOAD) begin
        item_r.tbl      <= in_load_table;
        item_r.layer_lo <= in_load_layer;
        item_r.layer_hi <= in_load_layer;
        item_r.row      <= RW'(in_load_row);
        item_r.col      <= CW'(in_load_col);
      end else begin
        item_r.tbl      <= in_current_select;
        item_r.layer_lo <= lay_lo;
        item_r.layer_hi <= lay_hi;
        item_r.row      <= '0;
        item_r.col      <= '0;
      end
    end else if (busy_r && ph_r == PH_REM) begin
      item_r.row <= row_clamp;
      item_r.fv  <= 16'(fv_prod >> mclut_pkg::FV_SH);
      rem_r      <= 7'(abs_r - 16'(row_r) * 16'(mclut_pkg::RPM_STEP));
    end else if (busy_r && ph_r == PH_FS) begin
      item_r.fs <= 16'(fs_prod >> mclut_pkg::FS_SH);
    end
  end

endmodule

// ===== hdl/mclut_queue.sv =====
module mclut_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mclut_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output mclut_pkg::item_t pop_item,
  output logic             empty
);

  localparam int DEPTH = mclut_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mclut_pkg::item_t ent_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      cnt_r;

  always_comb begin
    full     = (cnt_r == (PW+1)'(DEPTH));
    empty    = (cnt_r == '0);
    pop_item = ent_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/mclut_back.sv =====
module mclut_back #(
  parameter int SPEED_ROWS     = mclut_pkg::SPEED_ROWS_DEF,
  parameter int TORQUE_COLS    = mclut_pkg::TORQUE_COLS_DEF,
  parameter int VOLTAGE_LAYERS = mclut_pkg::VOLTAGE_LAYERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mclut_pkg::item_t   pop_item,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_current_value
);

  localparam int RW          = mclut_pkg::ROW_MAX_W;
  localparam int COL_W       = $clog2(TORQUE_COLS);
  localparam int CNT_W       = $clog2(TORQUE_COLS + 1);
  localparam int LAYER_WORDS = SPEED_ROWS * TORQUE_COLS;
  localparam int DEPTH       = VOLTAGE_LAYERS * LAYER_WORDS;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic signed [15:0] mem_t [DEPTH];
  logic signed [15:0] mem_d [DEPTH];
  logic signed [15:0] mem_q [DEPTH];
  logic signed [15:0] rd_t_r;
  logic signed [15:0] rd_d_r;
  logic signed [15:0] rd_q_r;

  logic [2:0]         st_r;
  mclut_pkg::item_t   cur_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [3:0]         rcnt_r;
  logic [3:0]         dcnt_r;
  logic [2:0]         step_r;
  logic [COL_W-1:0]   col_r;
  logic signed [15:0] tlo_r;
  logic [16:0]        rem_r;
  logic [15:0]        den_r;
  logic [15:0]        quo_r;
  logic [16:0]        ft_r;
  logic signed [15:0] x_r [8];
  logic signed [33:0] qa_r;
  logic signed [33:0] qb_r;
  logic signed [33:0] v_r [2];
  logic signed [33:0] r_r;
  logic signed [51:0] prod_r;
  logic               out_valid_r;
  logic signed [15:0] out_val_r;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [16:0] t_s;
  logic signed [16:0] rd_s;
  logic signed [16:0] tlo_s;
  logic               hit;
  logic [16:0]        r2;
  logic               qbit;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_c;
  logic signed [33:0] prod_q;
  logic signed [34:0] rnd;
  logic signed [18:0] rq;
  logic signed [15:0] sat;
  logic signed [15:0] rd_cur;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] layer,
                                                input logic [RW-1:0] row,
                                                input logic [8:0] col);
    addr_of = ADDR_W'(32'(layer) * LAYER_WORDS + 32'(row) * TORQUE_COLS + 32'(col));
  endfunction

  always_comb begin
    pop     = (st_r == S_IDLE) && !empty;
    wr_en   = pop && (pop_item.op == mclut_pkg::OP_LOAD);
    wr_addr = addr_of(pop_item.layer_lo, pop_item.row, 9'(pop_item.col));
    if (st_r == S_SRCH) begin
      rd_addr = addr_of(mclut_pkg::LAYER_400, cur_r.row + 1'b1, 9'(cnt_r));
    end else begin
      rd_addr = addr_of(rcnt_r[2] ? cur_r.layer_hi : cur_r.layer_lo,
                        cur_r.row + RW'(rcnt_r[1]), 9'(col_r) + 9'(rcnt_r[0]));
    end
    t_s    = $signed({1'b0, cur_r.trq});
    rd_s   = 17'(rd_t_r);
    tlo_s  = 17'(tlo_r);
    hit    = (t_s >= tlo_s) && (t_s < rd_s);
    r2     = {rem_r[15:0], 1'b0};
    qbit   = (r2 >= {1'b0, den_r});
    rd_cur = (cur_r.tbl == mclut_pkg::SEL_D) ? rd_d_r : rd_q_r;
    case (step_r)
      3'd0:    mul_a = 34'(x_r[1]) - 34'(x_r[0]);
      3'd1:    mul_a = 34'(x_r[3]) - 34'(x_r[2]);
      3'd3:    mul_a = 34'(x_r[5]) - 34'(x_r[4]);
      3'd4:    mul_a = 34'(x_r[7]) - 34'(x_r[6]);
      3'd6:    mul_a = v_r[1] - v_r[0];
      default: mul_a = qb_r - qa_r;
    endcase
    case (step_r)
      3'd2, 3'd5: mul_b = $signed({2'b00, cur_r.fs});
      3'd6:       mul_b = $signed({2'b00, cur_r.fv});
      default:    mul_b = $signed({1'b0, ft_r});
    endcase
    prod_c = mul_a * mul_b;
    prod_q = prod_r[49:16];
    rnd    = 35'(r_r) + 35'sd32768;
    rq     = rnd[34:16];
    if (rq > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (rq < -19'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = rq[15:0];
    end
    out_valid         = out_valid_r;
    out_current_value = out_val_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (pop_item.tbl)
        mclut_pkg::TBL_TORQUE: mem_t[wr_addr] <= pop_item.value;
        mclut_pkg::TBL_D:      mem_d[wr_addr] <= pop_item.value;
        default:               mem_q[wr_addr] <= pop_item.value;
      endcase
    end
    rd_t_r <= mem_t[rd_addr];
    rd_d_r <= mem_d[rd_addr];
    rd_q_r <= mem_q[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (pop && pop_item.op == mclut_pkg::OP_LOOKUP) begin
            if (pop_item.tbl == mclut_pkg::SEL_D || pop_item.tbl == mclut_pkg::SEL_Q) begin
              st_r <= S_SRCH;
            end else begin
              st_r <= S_OUT;
            end
          end
        end
        S_SRCH: begin
          if (cnt_r != '0 && cnt_r != CNT_W'(1)) begin
            if (hit) begin
              st_r <= S_DIV;
            end else if (cnt_r == CNT_W'(TORQUE_COLS)) begin
              st_r <= S_RD;
            end
          end
        end
        S_DIV:   if (dcnt_r == 4'd15) st_r <= S_RD;
        S_RD:    if (rcnt_r == 4'd8) st_r <= S_MUL;
        S_MUL:   st_r <= S_ACC;
        S_ACC:   st_r <= (step_r == 3'd6) ? S_OUT : S_MUL;
        S_OUT:   if (!out_valid_r || out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cur_r  <= pop_item;
        cnt_r  <= '0;
        step_r <= '0;
        r_r    <= '0;
      end
      S_SRCH: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          tlo_r <= rd_t_r;
        end else if (cnt_r != '0) begin
          if (hit) begin
            col_r  <= COL_W'(cnt_r - CNT_W'(2));
            rem_r  <= 17'(18'(t_s) - 18'(tlo_s));
            den_r  <= 16'(18'(rd_s) - 18'(tlo_s));
            dcnt_r <= '0;
            rcnt_r <= '0;
          end else begin
            tlo_r  <= rd_t_r;
            col_r  <= COL_W'(TORQUE_COLS - 2);
            ft_r   <= mclut_pkg::FRAC_ONE;
            rcnt_r <= '0;
          end
        end
      end
      S_DIV: begin
        rem_r  <= qbit ? 17'(r2 - {1'b0, den_r}) : r2;
        quo_r  <= {quo_r[14:0], qbit};
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 4'd15) ft_r <= {1'b0, quo_r[14:0], qbit};
      end
      S_RD: begin
        rcnt_r <= rcnt_r + 1'b1;
        if (rcnt_r != '0) x_r[3'(rcnt_r - 4'd1)] <= rd_cur;
        step_r <= '0;
      end
      S_MUL: prod_r <= prod_c;
      S_ACC: begin
        step_r <= step_r + 1'b1;
        case (step_r)
          3'd0:    qa_r <= {{2{x_r[0][15]}}, x_r[0], 16'b0} + prod_r[33:0];
          3'd1:    qb_r <= {{2{x_r[2][15]}}, x_r[2], 16'b0} + prod_r[33:0];
          3'd2:    v_r[0] <= qa_r + prod_q;
          3'd3:    qa_r <= {{2{x_r[4][15]}}, x_r[4], 16'b0} + prod_r[33:0];
          3'd4:    qb_r <= {{2{x_r[6][15]}}, x_r[6], 16'b0} + prod_r[33:0];
          3'd5:    v_r[1] <= qa_r + prod_q;
          default: r_r <= v_r[0] + prod_q;
        endcase
      end
      S_OUT: if (!out_valid_r || out_ready) out_val_r <= sat;
      default: cnt_r <= '0;
    endcase
  end

endmodule

// ===== hdl/motor_current_lut_interpolator.sv =====
// Motor current table interpolator.
// Input channel (in_valid/in_ready) takes either a table word write or a lookup.
// A write stores one word of the torque, d-axis or q-axis table and gives no
// result; writes outside the table space are dropped. A lookup gives exactly
// one result on the output channel (out_valid/out_ready): the current
// interpolated over speed, torque and bus voltage, rounded and saturated.
// The front stage takes one item at a time, none until it is done with the last, and
// classifies it; a two-entry queue decouples it from the back end.
// In a lookup the column search reads one torque word a cycle, the torque
// fraction comes from a 16-step restoring divider (skipped on a search miss),
// eight corner words are read one a cycle and a single shared multiplier runs
// seven products. The back end takes no new item until its lookup is done.
// A lookup with the current select outside the two tables skips all of it
// and gives zero. A write is stored in the back end as it is popped.
// Reset is synchronous and clears the control state; table contents are
// undefined until written. When out_ready is low the result is held in the
// output register, the back end waits on its next result and the queue and
// front keep taking items until the queue fills.
`include "motor_current_lut_interpolator_defines.svh"

module motor_current_lut_interpolator #(
  parameter int SPEED_ROWS     = mclut_pkg::SPEED_ROWS_DEF,
  parameter int TORQUE_COLS    = mclut_pkg::TORQUE_COLS_DEF,
  parameter int VOLTAGE_LAYERS = mclut_pkg::VOLTAGE_LAYERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [1:0]         in_load_table,
  input  logic [1:0]         in_load_layer,
  input  logic [6:0]         in_load_row,
  input  logic [4:0]         in_load_col,
  input  logic signed [15:0] in_load_value,
  input  logic signed [15:0] in_speed_rpm,
  input  logic signed [15:0] in_torque_request,
  input  logic [13:0]        in_bus_voltage,
  input  logic [1:0]         in_current_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_current_value
);

  mclut_pkg::item_t push_item;
  mclut_pkg::item_t pop_item;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  mclut_front #(
    .SPEED_ROWS     (SPEED_ROWS),
    .TORQUE_COLS    (TORQUE_COLS),
    .VOLTAGE_LAYERS (VOLTAGE_LAYERS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_load_table     (in_load_table),
    .in_load_layer     (in_load_layer),
    .in_load_row       (in_load_row),
    .in_load_col       (in_load_col),
    .in_load_value     (in_load_value),
    .in_speed_rpm      (in_speed_rpm),
    .in_torque_request (in_torque_request),
    .in_bus_voltage    (in_bus_voltage),
    .in_current_select (in_current_select),
    .push_item         (push_item),
    .push              (push),
    .full              (full)
  );

  mclut_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  mclut_back #(
    .SPEED_ROWS     (SPEED_ROWS),
    .TORQUE_COLS    (TORQUE_COLS),
    .VOLTAGE_LAYERS (VOLTAGE_LAYERS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_item          (pop_item),
    .empty             (empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_value (out_current_value)
  );

  `MCLUT_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !full)
  `MCLUT_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !empty)
  `MCLUT_ASSERT_RST(a_reset_no_out, clk, rst_n, !out_valid)

endmodule
